/* rtl/edd_pkg.sv */
package edd_pkg;

  // Field and register widths
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned ERR_W   = 14;
  localparam int unsigned FW_W    = 11;
  localparam int unsigned FH_W    = 13;
  localparam int unsigned TDATA_W = 8;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 3;

  // Parameter defaults
  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 4096;

  // Register reset values
  localparam logic [FW_W-1:0] FW_RESET = 11'd640;
  localparam logic [FH_W-1:0] FH_RESET = 13'd480;

  // Register select, taken from paddr[2]
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef logic signed [ERR_W-1:0] err_t;

  // Levels in 1/16 grey-code steps
  localparam err_t WHITE_LEVEL = 14'sd4080;
  localparam err_t THRESHOLD   = 14'sd2040;

  // Position flags of the pixel in the compute stage
  typedef struct packed {
    logic first_col;
    logic last_col;
    logic last_row;
  } pos_t;

endpackage

/* rtl/edd_cfg.sv */
module edd_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [edd_pkg::APB_AW-1:0]     paddr,
  input  logic [edd_pkg::APB_DW-1:0]     pwdata,
  output logic [edd_pkg::APB_DW-1:0]     prdata,
  output logic                           pready,
  output logic [edd_pkg::FW_W-1:0]       frame_width_o,
  output logic [edd_pkg::FH_W-1:0]       frame_height_o
);
  import edd_pkg::*;

  logic [FW_W-1:0] frame_width_q, frame_width_d;
  logic [FH_W-1:0] frame_height_q, frame_height_d;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    frame_width_d  = frame_width_q;
    frame_height_d = frame_height_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_FRAME_WIDTH:  frame_width_d  = pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_d = pwdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FRAME_WIDTH:  prdata = APB_DW'(frame_width_q);
      REG_FRAME_HEIGHT: prdata = APB_DW'(frame_height_q);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FW_RESET;
      frame_height_q <= FH_RESET;
    end else begin
      frame_width_q  <= frame_width_d;
      frame_height_q <= frame_height_d;
    end
  end

  assign frame_width_o  = frame_width_q;
  assign frame_height_o = frame_height_q;

endmodule

/* rtl/edd_err_ram.sv */
module edd_err_ram #(
  parameter int unsigned DEPTH = edd_pkg::DEF_MAX_WIDTH,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  edd_pkg::err_t    wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output edd_pkg::err_t    rdata_o
);
  import edd_pkg::*;

  err_t mem [DEPTH];
  err_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/edd_diffuse.sv */
module edd_diffuse (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  logic [edd_pkg::PIX_W-1:0]  pixel_i,
  input  edd_pkg::pos_t              pos_i,
  input  edd_pkg::err_t              err_below_i,
  output logic                       pixel_on_o,
  output edd_pkg::err_t              wr_left_o,
  output edd_pkg::err_t              wr_here_o
);
  import edd_pkg::*;

  localparam int unsigned SUM_W  = 16;
  localparam int unsigned PROD_W = 18;

  function automatic err_t sat14(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] lo;
    logic signed [SUM_W-1:0] hi;
    lo = -(SUM_W'(signed'(1)) <<< (ERR_W-1));
    hi = (SUM_W'(signed'(1)) <<< (ERR_W-1)) - SUM_W'(signed'(1));
    if (v < lo) return err_t'(lo);
    if (v > hi) return err_t'(hi);
    return err_t'(v);
  endfunction

  err_t rc_q, rc_d;     // 7/16 share to the right
  err_t pbl_q, pbl_d;   // pending below-left
  err_t pb_q, pb_d;     // pending below

  logic signed [SUM_W-1:0]  sum;
  err_t                     corrected, err_c;
  logic signed [PROD_W-1:0] p7, p5, p3;
  err_t                     s7, s5, s3, s1;
  err_t                     pbl_new;
  logic                     on;
  logic                     no_below;

  always_comb begin
    sum = $signed({4'b0000, pixel_i, 4'b0000}) + SUM_W'(rc_q) + SUM_W'(err_below_i);
    corrected = sat14(sum);
    on    = corrected > THRESHOLD;
    err_c = on ? (corrected - WHITE_LEVEL) : corrected;

    // x*k as shift-adds; floor division by 16 is an arithmetic shift
    p7 = (PROD_W'(err_c) <<< 3) - PROD_W'(err_c);
    p5 = (PROD_W'(err_c) <<< 2) + PROD_W'(err_c);
    p3 = (PROD_W'(err_c) <<< 1) + PROD_W'(err_c);

    no_below = pos_i.last_row;
    s7 = pos_i.last_col ? '0 : err_t'(p7 >>> 4);
    s3 = (no_below || pos_i.first_col) ? '0 : err_t'(p3 >>> 4);
    s5 = no_below ? '0 : err_t'(p5 >>> 4);
    s1 = (no_below || pos_i.last_col) ? '0 : err_t'(err_c >>> 4);

    wr_left_o = sat14(SUM_W'(pbl_q) + SUM_W'(s3));
    pbl_new   = sat14(SUM_W'(pb_q) + SUM_W'(s5));
    wr_here_o = pbl_new;

    rc_d  = rc_q;
    pbl_d = pbl_q;
    pb_d  = pb_q;
    if (fire_i) begin
      if (pos_i.last_col) begin
        rc_d  = '0;
        pbl_d = '0;
        pb_d  = '0;
      end else begin
        rc_d  = s7;
        pbl_d = pbl_new;
        pb_d  = s1;
      end
    end
  end

  assign pixel_on_o = on;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q  <= '0;
      pbl_q <= '0;
      pb_q  <= '0;
    end else begin
      rc_q  <= rc_d;
      pbl_q <= pbl_d;
      pb_q  <= pb_d;
    end
  end

endmodule

/* rtl/error_diffusion_dither_core.sv */
// Floyd-Steinberg ditherer: takes 8-bit grey pixels in raster order and returns one
// black/white bit per pixel, with tlast marking the last pixel of the frame. It sustains
// one pixel per clock while the output is not stalled; each result is registered (the
// next-row error memory is read on the accepting edge, and the diffusion arithmetic runs
// from that registered data into the output register once the compute stage fires). The
// carried errors live in a MAX_WIDTH-entry memory, read at the current column and written
// one column behind, plus three pending registers for the right and below shares. After
// reset the block zeroes that memory and holds s_axis_tready low meanwhile; APB writes
// are taken at all times. frame_width (offset 0) and frame_height (offset 4) may only be
// changed while no pixel is in flight; 0 acts as 1, values above MAX_WIDTH / MAX_HEIGHT
// are clipped.
module error_diffusion_dither_core #(
  parameter int unsigned MAX_WIDTH  = edd_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = edd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // pixel requests
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [edd_pkg::PIX_W-1:0]     s_axis_tdata,   // [7:0] pixel
  // dithered results
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [edd_pkg::TDATA_W-1:0]   m_axis_tdata,   // [0] pixel_on, [7:1] zero
  output logic                          m_axis_tlast,   // end_of_frame
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [edd_pkg::APB_AW-1:0]    paddr,
  input  logic [edd_pkg::APB_DW-1:0]    pwdata,
  output logic [edd_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import edd_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  // --- configuration ---
  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;

  edd_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .frame_width_o  (frame_width),
    .frame_height_o (frame_height)
  );

  // effective frame size
  logic [31:0] w_eff, h_eff;
  always_comb begin
    if (frame_width == '0)                  w_eff = 32'd1;
    else if (32'(frame_width) > MAX_WIDTH)  w_eff = 32'(MAX_WIDTH);
    else                                    w_eff = 32'(frame_width);
    if (frame_height == '0)                 h_eff = 32'd1;
    else if (32'(frame_height) > MAX_HEIGHT) h_eff = 32'(MAX_HEIGHT);
    else                                    h_eff = 32'(frame_height);
  end

  // --- post-reset memory clear ---
  logic          clr_busy_q, clr_busy_d;
  logic [CW-1:0] clr_addr_q, clr_addr_d;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + CW'(1);
      if (clr_addr_q == CW'(MAX_WIDTH - 1)) clr_busy_d = 1'b0;
    end
  end

  // --- handshake ---
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic accept, fire;

  assign fire          = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !clr_busy_q && (!s1_valid_q || fire);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // --- position tracking at the request side ---
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  pos_t          pos_in;

  always_comb begin
    pos_in.first_col = (col_q == '0);
    pos_in.last_col  = (32'(col_q) + 32'd1) >= w_eff;
    pos_in.last_row  = (32'(row_q) + 32'd1) >= h_eff;
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (pos_in.last_col) begin
        col_d = '0;
        row_d = pos_in.last_row ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  // --- compute stage registers ---
  logic [PIX_W-1:0] s1_pix_q;
  logic [CW-1:0]    s1_x_q;
  pos_t             s1_pos_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept)    s1_valid_d = 1'b1;
    else if (fire) s1_valid_d = 1'b0;
  end

  // --- error memory and write arbitration ---
  // Below-left write goes out with the pixel; the last column's own entry is
  // held in a deferred slot and lands on the next cycle (always a first column).
  logic          we;
  logic [CW-1:0] waddr;
  err_t          wdata;
  err_t          rdata;
  err_t          wr_left, wr_here;
  logic          wr_left_en;

  logic          defer_valid_q, defer_valid_d;
  logic [CW-1:0] defer_addr_q;
  err_t          defer_data_q;

  assign wr_left_en = fire && !s1_pos_q.first_col;

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    priority if (clr_busy_q) begin
      we    = 1'b1;
      waddr = clr_addr_q;
    end else if (wr_left_en) begin
      we    = 1'b1;
      waddr = s1_x_q - CW'(1);
      wdata = wr_left;
    end else if (defer_valid_q) begin
      we    = 1'b1;
      waddr = defer_addr_q;
      wdata = defer_data_q;
    end
  end

  always_comb begin
    defer_valid_d = defer_valid_q;
    if (fire && s1_pos_q.last_col) begin
      defer_valid_d = 1'b1;
    end else if (defer_valid_q && !clr_busy_q && !wr_left_en) begin
      defer_valid_d = 1'b0;
    end
  end

  edd_err_ram #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (rdata)
  );

  // forwarding: a write that hits the entry being read (or held) overrides
  // the registered memory data; the deferred slot is always the newest
  logic fwd_valid_q, fwd_valid_d;
  err_t fwd_data_q, fwd_data_d;
  err_t err_below;

  always_comb begin
    fwd_valid_d = fwd_valid_q;
    fwd_data_d  = fwd_data_q;
    if (accept) begin
      fwd_valid_d = we && (waddr == col_q);
      fwd_data_d  = wdata;
    end else if (s1_valid_q && we && (waddr == s1_x_q)) begin
      fwd_valid_d = 1'b1;
      fwd_data_d  = wdata;
    end
  end

  always_comb begin
    if (defer_valid_q && (defer_addr_q == s1_x_q)) err_below = defer_data_q;
    else if (fwd_valid_q)                           err_below = fwd_data_q;
    else                                            err_below = rdata;
  end

  // --- diffusion arithmetic ---
  logic pixel_on;

  edd_diffuse u_diffuse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .pixel_i     (s1_pix_q),
    .pos_i       (s1_pos_q),
    .err_below_i (err_below),
    .pixel_on_o  (pixel_on),
    .wr_left_o   (wr_left),
    .wr_here_o   (wr_here)
  );

  // --- output register ---
  logic out_on_q, out_eof_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire)               out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDATA_W'(out_on_q);
  assign m_axis_tlast  = out_eof_q;

  // --- registers ---
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q    <= 1'b1;
      clr_addr_q    <= '0;
      col_q         <= '0;
      row_q         <= '0;
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      defer_valid_q <= 1'b0;
      fwd_valid_q   <= 1'b0;
    end else begin
      clr_busy_q    <= clr_busy_d;
      clr_addr_q    <= clr_addr_d;
      col_q         <= col_d;
      row_q         <= row_d;
      s1_valid_q    <= s1_valid_d;
      out_valid_q   <= out_valid_d;
      defer_valid_q <= defer_valid_d;
      fwd_valid_q   <= fwd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= fwd_data_d;
    if (accept) begin
      s1_pix_q <= s_axis_tdata;
      s1_x_q   <= col_q;
      s1_pos_q <= pos_in;
    end
    if (fire && s1_pos_q.last_col) begin
      defer_addr_q <= s1_x_q;
      defer_data_q <= wr_here;
    end
    if (fire) begin
      out_on_q  <= pixel_on;
      out_eof_q <= s1_pos_q.last_col && s1_pos_q.last_row;
    end
  end

  // --- assertions ---
  a_no_left_write_with_defer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_left_en |-> !defer_valid_q)
    else $error("below-left write collides with deferred write");

  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !s_axis_tready)
    else $error("request taken during memory clear");

  a_row_wraps_to_first_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && s1_pos_q.last_col) |-> (col_q == '0))
    else $error("column count not wrapped after last column");

  a_full_pipe_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("request taken while compute stage is blocked");

endmodule

/* tb/error_diffusion_dither_core_tb.sv */
module error_diffusion_dither_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import edd_pkg::*;

  localparam int MAX_W          = DEF_MAX_WIDTH;
  localparam int MAX_H          = DEF_MAX_HEIGHT;
  localparam int MAX_IDLE       = 16;
  localparam int WATCHDOG_LIMIT = 4000;   // must outlast the reset clear of the error store
  localparam int RANDOM_PIXELS  = 300;
  localparam int LONG_RUN       = 100;
  localparam int SHOWN_ERRORS   = 10;
  localparam int ERR_LO         = -8192;
  localparam int ERR_HI         = 8191;

  // 4x3 opening frame: both extremes, both sides of the threshold, alternating bits
  localparam logic [7:0] OPENING_FRAME [12] = '{
    8'd0, 8'd255, 8'd128, 8'd127,
    8'd1, 8'd254, 8'h55,  8'hAA,
    8'd127, 8'd128, 8'd0, 8'd255
  };

  typedef enum int {
    TONE_UNIFORM, TONE_EXTREMES, TONE_NEAR_THRESHOLD, TONE_DARK, TONE_BRIGHT, TONE_FLAT
  } tone_e;

  // one dithered result as it should come out
  typedef struct packed {
    logic on;
    logic eof;
  } dot_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  wire                  s_axis_tready;
  logic [PIX_W-1:0]     s_axis_tdata  = '0;   // [7:0] pixel
  wire                  m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  wire  [TDATA_W-1:0]   m_axis_tdata;         // [0] pixel_on, [7:1] zero
  wire                  m_axis_tlast;         // end_of_frame
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [APB_AW-1:0]    paddr         = '0;
  logic [APB_DW-1:0]    pwdata        = '0;
  wire  [APB_DW-1:0]    prdata;
  wire                  pready;

  error_diffusion_dither_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow of the ditherer: size registers, carried errors and raster position.
  // All errors are in 1/16 grey-code steps, saturated to 14-bit signed.
  // ---------------------------------------------------------------------------
  logic [FW_W-1:0] width_reg      = FW_RESET;
  logic [FH_W-1:0] height_reg     = FH_RESET;
  err_t            err_row [MAX_W] = '{default: '0};  // error flowing into each column
  err_t            carry_right    = '0;
  err_t            below_left_acc = '0;
  err_t            below_acc      = '0;
  logic [9:0]      col_pos        = '0;
  logic [11:0]     row_pos        = '0;

  dot_t expected_dots [$];
  int   mismatches     = 0;
  int   results_seen   = 0;
  int   idle_cycles    = 0;
  int   random_sent    = 0;
  bit   calm           = 1'b0;   // both sides run without gaps while set

  function automatic int clip_err(input int v);
    return (v < ERR_LO) ? ERR_LO : (v > ERR_HI) ? ERR_HI : v;
  endfunction

  // Works out one pixel's result and advances the shadow state.
  function automatic void dither_predict(input logic [7:0] pix, output dot_t dot);
    int   w, h, x, y, corrected, err, s7, s3, s5, s1;
    logic first_col, last_col, last_row, on;
    w = (width_reg == 0) ? 1 : (width_reg > MAX_W) ? MAX_W : int'(width_reg);
    h = (height_reg == 0) ? 1 : (height_reg > MAX_H) ? MAX_H : int'(height_reg);
    x = int'(col_pos) % MAX_W;
    y = int'(row_pos) % MAX_H;
    first_col = (x == 0);
    // a position left past the edge by a size change counts as the edge
    last_col  = (x + 1 >= w);
    last_row  = (y + 1 >= h);

    corrected = clip_err(int'(pix) * 16 + int'(carry_right) + int'(err_row[x]));
    on  = (corrected > int'(THRESHOLD));
    err = corrected - (on ? int'(WHITE_LEVEL) : 0);

    // shares floor toward minus infinity; those leaving the frame are dropped
    s7 = last_col                ? 0 : (err * 7) >>> 4;
    s3 = (last_row || first_col) ? 0 : (err * 3) >>> 4;
    s5 = last_row                ? 0 : (err * 5) >>> 4;
    s1 = (last_row || last_col)  ? 0 : err >>> 4;

    if (!first_col) err_row[x - 1] = err_t'(clip_err(int'(below_left_acc) + s3));
    below_left_acc = err_t'(clip_err(int'(below_acc) + s5));
    below_acc      = err_t'(s1);
    carry_right    = err_t'(clip_err(s7));

    dot.on  = on;
    dot.eof = last_col && last_row;

    if (last_col) begin
      err_row[x]     = below_left_acc;
      below_left_acc = '0;
      below_acc      = '0;
      carry_right    = '0;
      col_pos        = '0;
      row_pos        = last_row ? '0 : 12'(y + 1);
    end else begin
      col_pos = 10'(x + 1);
    end
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= SHOWN_ERRORS)
      $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
  endtask

  function automatic logic [7:0] pick_pixel(input tone_e tone, input logic [7:0] level);
    case (tone)
      TONE_EXTREMES:       return $urandom_range(1, 0) ? 8'hFF : 8'h00;
      TONE_NEAR_THRESHOLD: return 8'($urandom_range(135, 120));
      TONE_DARK:           return 8'($urandom_range(40, 0));
      TONE_BRIGHT:         return 8'($urandom_range(255, 215));
      TONE_FLAT:           return level;
      default:             return 8'($urandom_range(255, 0));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Pixel side: one request per call, random gap in front. tvalid stays high
  // into the next call when that one has no gap.
  // ---------------------------------------------------------------------------
  task automatic send_pixel(input logic [7:0] pix);
    int   gap;
    dot_t dot;
    gap = calm ? 0 : $urandom_range(MAX_IDLE, 0);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    dither_predict(pix, dot);
    expected_dots = {expected_dots, dot};
  endtask

  // Stop sending and wait for every outstanding result, plus the pipeline depth
  // so the last error-store write has landed before sizes change.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_dots.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // APB: setup then access; the write lands on the access edge (pready tied high)
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic reg_sel, input logic [APB_DW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (reg_sel == REG_FRAME_WIDTH) width_reg = value[FW_W-1:0];
    else height_reg = value[FH_W-1:0];
  endtask

  task automatic check_reg(input logic reg_sel);
    logic [APB_DW-1:0] want;
    want = (reg_sel == REG_FRAME_WIDTH) ? APB_DW'(width_reg) : APB_DW'(height_reg);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {reg_sel, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want)
      flag_mismatch(reg_sel == REG_FRAME_WIDTH ? "frame_width read" : "frame_height read",
                    want, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // only called with the block idle
  task automatic set_size(input int unsigned w, input int unsigned h);
    write_reg(REG_FRAME_WIDTH, APB_DW'(w));
    write_reg(REG_FRAME_HEIGHT, APB_DW'(h));
    check_reg(REG_FRAME_WIDTH);
    check_reg(REG_FRAME_HEIGHT);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall before each result, then hold tready until taken
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    forever begin
      stall = calm ? 0 : $urandom_range(MAX_IDLE, 0);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid === 1'b1 && rst_ni));
    end
  end

  // Each taken result against the oldest expectation, field by field
  always @(posedge clk_i) begin : result_check
    dot_t want;
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      results_seen++;
      if (expected_dots.size() == 0) begin
        flag_mismatch($sformatf("result %0d with nothing pending", results_seen),
                      '0, 32'(m_axis_tdata));
      end else begin
        want = expected_dots.pop_front();
        if (m_axis_tdata[0] !== want.on)
          flag_mismatch($sformatf("result %0d pixel_on", results_seen),
                        32'(want.on), 32'(m_axis_tdata[0]));
        if (m_axis_tlast !== want.eof)
          flag_mismatch($sformatf("result %0d end_of_frame", results_seen),
                        32'(want.eof), 32'(m_axis_tlast));
        if (m_axis_tdata[TDATA_W-1:1] !== '0)
          flag_mismatch($sformatf("result %0d tdata padding", results_seen),
                        '0, 32'(m_axis_tdata[TDATA_W-1:1]));
      end
    end
  end

  // Watchdog: too long without any request taken on either side ends the run
  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
        (m_axis_tvalid === 1'b1 && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("error_diffusion_dither_core_tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers come up at 640 x 480; reads work while the store is being cleared
  task automatic test_reset_values();
    check_reg(REG_FRAME_WIDTH);
    check_reg(REG_FRAME_HEIGHT);
  endtask

  // Small frames by hand: edges, threshold on both sides, zero sizes, and a
  // size cut while the position sits past the new last column, on the last row
  task automatic test_directed_frames();
    set_size(4, 3);
    foreach (OPENING_FRAME[i]) send_pixel(OPENING_FRAME[i]);
    settle();
    set_size(0, 0);                // acts as 1x1: every pixel ends a frame
    send_pixel(8'd200);
    send_pixel(8'd100);
    settle();
    set_size(5, 4);
    send_pixel(8'd90);
    send_pixel(8'd160);
    send_pixel(8'd40);
    settle();
    set_size(2, 1);                // column 3 now beyond the row end, row 0 last
    send_pixel(8'd250);
    settle();
  endtask

  // Long row at the maximum width, then an oversize width that clips to it with
  // the position kept, then the row closed off and the next one read back as the
  // last row of a narrow frame
  task automatic test_max_width();
    set_size(MAX_W, 8191);
    calm = 1'b1;
    repeat (LONG_RUN) send_pixel(8'($urandom_range(255, 0)));
    settle();
    calm = 1'b0;
    set_size(2047, 8191);
    repeat (LONG_RUN) send_pixel(8'($urandom_range(255, 0)));
    settle();
    set_size(3, 2);
    repeat (3) send_pixel(8'($urandom_range(255, 0)));
    settle();
  endtask

  // Runs of random length under random sizes (mostly small so frames close
  // often), with varied pixel tones; each run ends in a full drain
  task automatic test_random_frames();
    int unsigned w, h;
    int          run_len;
    tone_e       tone;
    logic [7:0]  level;
    while (random_sent < RANDOM_PIXELS) begin
      case ($urandom_range(11, 0))
        0:       w = 0;
        1:       w = $urandom_range(2047, MAX_W + 1);
        2:       w = 1;
        default: w = $urandom_range(12, 1);
      endcase
      case ($urandom_range(11, 0))
        0:       h = 0;
        1:       h = $urandom_range(8191, MAX_H + 1);
        2:       h = MAX_H;
        default: h = $urandom_range(6, 1);
      endcase
      set_size(w, h);
      calm    = ($urandom_range(4, 0) == 0);
      tone    = tone_e'($urandom_range(int'(TONE_FLAT), int'(TONE_UNIFORM)));
      level   = 8'($urandom_range(255, 0));
      run_len = $urandom_range(60, 10);
      repeat (run_len) begin
        send_pixel(pick_pixel(tone, level));
        random_sent++;
      end
      settle();
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_values();
    test_directed_frames();
    test_max_width();
    test_random_frames();
    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("error_diffusion_dither_core_tb OK");
    end else begin
      $display("error_diffusion_dither_core_tb NOT OK");
    end
    $finish;
  end

endmodule
